// ----- rtl/iee_pkg.sv -----
`default_nettype none
package iee_pkg;

	localparam int DEF_STACK_DEPTH = 32;
	localparam int DEF_VALUE_WIDTH = 32;
	localparam int QDEPTH = 4;

	// operator codes as kept on the operator stack
	localparam logic [2:0] OP_LPAR = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;
	localparam logic [2:0] OP_MOD  = 3'd5;
	localparam logic [2:0] OP_POW  = 3'd6;

	// status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_MAL  = 2'd1;
	localparam logic [1:0] STAT_DIV0 = 2'd2;
	localparam logic [1:0] STAT_OVF  = 2'd3;

	// characters
	localparam logic [7:0] CH_ADD  = 8'h2B;
	localparam logic [7:0] CH_SUB  = 8'h2D;
	localparam logic [7:0] CH_MUL  = 8'h2A;
	localparam logic [7:0] CH_DIV  = 8'h2F;
	localparam logic [7:0] CH_MOD  = 8'h25;
	localparam logic [7:0] CH_POW  = 8'h5E;
	localparam logic [7:0] CH_LPAR = 8'h28;
	localparam logic [7:0] CH_RPAR = 8'h29;
	localparam logic [7:0] CH_D0   = 8'h30;
	localparam logic [7:0] CH_D9   = 8'h39;

	typedef enum logic [2:0] {
		TK_NONE,
		TK_DIGIT,
		TK_LPAR,
		TK_RPAR,
		TK_OPER
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t  kind;
		logic [3:0] digit;
		logic [2:0] op;
		logic       last;
	} tok_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result;
		logic [1:0]         status;
	} rsp_t;

	function automatic logic [1:0] prec(input logic [2:0] op);
		logic [1:0] p;
		case (op)
			OP_ADD, OP_SUB:         p = 2'd1;
			OP_MUL, OP_DIV, OP_MOD: p = 2'd2;
			OP_POW:                 p = 2'd3;
			default:                p = 2'd0;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/infix_expression_evaluator.sv -----
`default_nettype none
// channel   direction  handshake             payload
// req       in         push / full           ch[7:0], last
// rsp       out        empty / pop           result[31:0] signed, status[1:0]
//
// Back end steps per item: a digit, '(' or ignored character is taken in the idle
// state, an operator passes through S_OPR and ')' through S_RPAR and S_LOAD, and each
// operator applied passes through S_LOAD and S_EXEC. Divide and modulo then iterate in
// S_DIV (one quotient bit per cycle), power in S_POW (none for a negative exponent).
// The last character applies the pending operators in S_FIN, then S_DONE posts the
// result, and holds while the previous result still waits to be popped.
// A 4-entry token queue lets characters arrive while the back end works.
// Reset clears both stack counts; stack contents need no clearing.
module infix_expression_evaluator
	import iee_pkg::*;
#(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic push,
	output logic       full,
	input  wire  req_t req,
	output logic       empty,
	input  wire  logic pop,
	output rsp_t       rsp
);

	tok_t tok;
	logic tok_valid;
	logic tok_pop;

	// classify characters and queue them
	iee_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.tok       (tok),
		.tok_valid (tok_valid),
		.tok_pop   (tok_pop)
	);

	// evaluate on the two stacks
	iee_back #(
		.STACK_DEPTH (STACK_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (tok),
		.tok_valid (tok_valid),
		.tok_pop   (tok_pop),
		.rsp       (rsp),
		.empty     (empty),
		.pop       (pop)
	);

endmodule
`default_nettype wire

// ----- rtl/iee_front.sv -----
`default_nettype none
module iee_front
	import iee_pkg::*;
(
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic push,
	output logic       full,
	input  wire  req_t req,
	output tok_t       tok,
	output logic       tok_valid,
	input  wire  logic tok_pop
);

	localparam int PW = $clog2(QDEPTH);

	tok_t           cls;
	tok_t           q_mem [QDEPTH];
	logic [PW-1:0]  wp_q;
	logic [PW-1:0]  rp_q;
	logic [PW:0]    cnt_q;
	logic           wr;
	logic           rd;

	// classify the character
	always_comb begin
		cls.kind  = TK_NONE;
		cls.digit = req.ch[3:0];
		cls.op    = OP_LPAR;
		cls.last  = req.last;
		if (req.ch >= CH_D0 && req.ch <= CH_D9) begin
			cls.kind = TK_DIGIT;
		end else begin
			case (req.ch)
				CH_LPAR: cls.kind = TK_LPAR;
				CH_RPAR: cls.kind = TK_RPAR;
				CH_ADD:  begin cls.kind = TK_OPER; cls.op = OP_ADD; end
				CH_SUB:  begin cls.kind = TK_OPER; cls.op = OP_SUB; end
				CH_MUL:  begin cls.kind = TK_OPER; cls.op = OP_MUL; end
				CH_DIV:  begin cls.kind = TK_OPER; cls.op = OP_DIV; end
				CH_MOD:  begin cls.kind = TK_OPER; cls.op = OP_MOD; end
				CH_POW:  begin cls.kind = TK_OPER; cls.op = OP_POW; end
				default: cls.kind = TK_NONE;
			endcase
		end
	end

	assign full      = (cnt_q == (PW+1)'(QDEPTH));
	assign tok_valid = (cnt_q != '0);
	assign wr        = push && !full;
	assign rd        = tok_pop && tok_valid;
	assign tok       = q_mem[rp_q];

	// token queue storage
	always_ff @(posedge clk) begin
		if (wr) begin
			q_mem[wp_q] <= cls;
		end
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			if (wr && !rd) cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/iee_back.sv -----
`default_nettype none
module iee_back
	import iee_pkg::*;
#(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  tok_t tok,
	input  wire  logic tok_valid,
	output logic       tok_pop,
	output rsp_t       rsp,
	output logic       empty,
	input  wire  logic pop
);

	localparam int W  = VALUE_WIDTH;
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int DW = $clog2(VALUE_WIDTH + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_RPAR, S_OPR, S_FIN, S_LOAD, S_EXEC, S_DIV, S_POW, S_DONE
	} state_t;

	state_t         state_q;
	state_t         ret_q;
	logic           last_q;
	logic [1:0]     err_q;
	logic [CW-1:0]  vcnt_q;
	logic [CW-1:0]  ocnt_q;
	logic [W-1:0]   tv_q;
	logic [2:0]     top_q;
	logic [2:0]     cur_q;
	logic [2:0]     aop_q;
	logic           app_q;
	logic [W-1:0]   rem_q;
	logic [W-1:0]   quo_q;
	logic [W-1:0]   dvs_q;
	logic           neg_q;
	logic [DW-1:0]  dcnt_q;
	logic [W-1:0]   pr_q;
	logic [W-1:0]   pb_q;
	logic [W-1:0]   pe_q;
	logic           ovalid_q;
	rsp_t           rsp_q;

	logic [W-1:0]   vmem [STACK_DEPTH];
	logic [2:0]     omem [STACK_DEPTH];
	logic [W-1:0]   vrd_q;
	logic [2:0]     ord_q;

	logic           v_push;
	logic           o_push;
	logic [2:0]     o_new;
	logic           opr_pop;
	logic           idle_go;
	state_t         after;
	logic [W-1:0]   x;
	logic [W-1:0]   y;
	logic [W-1:0]   ux;
	logic [W-1:0]   uy;
	logic [W-1:0]   sum;
	logic [W-1:0]   dif;
	logic [W-1:0]   prod;
	logic [W-1:0]   pmul_r;
	logic [W-1:0]   pmul_b;
	logic [W:0]     r2;
	logic           vfull;
	logic           ofull;

	assign idle_go = (state_q == S_IDLE) && tok_valid;
	assign tok_pop = idle_go;
	assign vfull   = (vcnt_q >= CW'(STACK_DEPTH));
	assign ofull   = (ocnt_q >= CW'(STACK_DEPTH));
	assign after   = last_q ? S_FIN : S_IDLE;
	assign opr_pop = (ocnt_q != '0) && (top_q != OP_LPAR) && (prec(top_q) >= prec(cur_q));

	// decide stack pushes
	always_comb begin
		v_push = idle_go && (err_q == STAT_OK) && (tok.kind == TK_DIGIT) && !vfull;
		o_push = 1'b0;
		o_new  = OP_LPAR;
		if (idle_go && (err_q == STAT_OK) && (tok.kind == TK_LPAR) && !ofull) begin
			o_push = 1'b1;
		end
		if ((state_q == S_OPR) && (err_q == STAT_OK) && !opr_pop && !ofull) begin
			o_push = 1'b1;
			o_new  = cur_q;
		end
	end

	// operands and combinational arithmetic
	assign x      = vrd_q;
	assign y      = tv_q;
	assign ux     = x[W-1] ? (~x + 1'b1) : x;
	assign uy     = y[W-1] ? (~y + 1'b1) : y;
	assign sum    = x + y;
	assign dif    = x - y;
	assign prod   = x * y;
	assign pmul_r = pr_q * pb_q;
	assign pmul_b = pb_q * pb_q;
	assign r2     = {rem_q, quo_q[W-1]};

	// value stack below the top register
	always_ff @(posedge clk) begin
		if (v_push && (vcnt_q != '0)) begin
			vmem[AW'(vcnt_q - 1'b1)] <= tv_q;
		end
		vrd_q <= vmem[AW'(vcnt_q - 2'd2)];
	end

	// operator stack below the top register
	always_ff @(posedge clk) begin
		if (o_push && (ocnt_q != '0)) begin
			omem[AW'(ocnt_q - 1'b1)] <= top_q;
		end
		ord_q <= omem[AW'(ocnt_q - 2'd2)];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_q    <= S_IDLE;
			last_q   <= 1'b0;
			err_q    <= STAT_OK;
			vcnt_q   <= '0;
			ocnt_q   <= '0;
			app_q    <= 1'b0;
			dcnt_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (pop && ovalid_q) ovalid_q <= 1'b0;
			if (v_push) begin
				tv_q   <= W'(tok.digit);
				vcnt_q <= vcnt_q + 1'b1;
			end
			if (o_push) begin
				top_q  <= o_new;
				ocnt_q <= ocnt_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (tok_valid) begin
						last_q <= tok.last;
						if (err_q != STAT_OK) begin
							state_q <= tok.last ? S_DONE : S_IDLE;
						end else begin
							case (tok.kind)
								TK_DIGIT: begin
									if (!v_push) err_q <= STAT_OVF;
									state_q <= tok.last ? S_FIN : S_IDLE;
								end
								TK_LPAR: begin
									if (!o_push) err_q <= STAT_OVF;
									state_q <= tok.last ? S_FIN : S_IDLE;
								end
								TK_RPAR: state_q <= S_RPAR;
								TK_OPER: begin
									cur_q   <= tok.op;
									state_q <= S_OPR;
								end
								default: state_q <= tok.last ? S_FIN : S_IDLE;
							endcase
						end
					end
				end
				S_RPAR: begin
					if (err_q != STAT_OK) begin
						state_q <= after;
					end else if (ocnt_q == '0) begin
						err_q   <= STAT_MAL;
						state_q <= after;
					end else begin
						ocnt_q  <= ocnt_q - 1'b1;
						aop_q   <= top_q;
						app_q   <= (top_q != OP_LPAR);
						ret_q   <= (top_q != OP_LPAR) ? S_RPAR : after;
						state_q <= S_LOAD;
					end
				end
				S_OPR: begin
					if (err_q != STAT_OK) begin
						state_q <= after;
					end else if (opr_pop) begin
						ocnt_q  <= ocnt_q - 1'b1;
						aop_q   <= top_q;
						app_q   <= 1'b1;
						ret_q   <= S_OPR;
						state_q <= S_LOAD;
					end else begin
						if (ofull) err_q <= STAT_OVF;
						state_q <= after;
					end
				end
				S_FIN: begin
					if ((err_q == STAT_OK) && (ocnt_q != '0)) begin
						if (top_q == OP_LPAR) begin
							err_q   <= STAT_MAL;
							state_q <= S_DONE;
						end else begin
							ocnt_q  <= ocnt_q - 1'b1;
							aop_q   <= top_q;
							app_q   <= 1'b1;
							ret_q   <= S_FIN;
							state_q <= S_LOAD;
						end
					end else begin
						if ((err_q == STAT_OK) && (vcnt_q != CW'(1))) err_q <= STAT_MAL;
						state_q <= S_DONE;
					end
				end
				S_LOAD: begin
					// refill the operator top, wait for the second operand
					top_q <= ord_q;
					if (!app_q) begin
						state_q <= ret_q;
					end else if (vcnt_q < CW'(2)) begin
						err_q   <= STAT_MAL;
						state_q <= ret_q;
					end else begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (aop_q)
						OP_ADD: begin
							tv_q <= sum; vcnt_q <= vcnt_q - 1'b1; state_q <= ret_q;
						end
						OP_SUB: begin
							tv_q <= dif; vcnt_q <= vcnt_q - 1'b1; state_q <= ret_q;
						end
						OP_MUL: begin
							tv_q <= prod; vcnt_q <= vcnt_q - 1'b1; state_q <= ret_q;
						end
						OP_DIV, OP_MOD: begin
							if (y == '0) begin
								err_q   <= STAT_DIV0;
								state_q <= ret_q;
							end else begin
								rem_q   <= '0;
								quo_q   <= ux;
								dvs_q   <= uy;
								neg_q   <= (aop_q == OP_DIV) ? (x[W-1] ^ y[W-1]) : x[W-1];
								dcnt_q  <= DW'(W);
								state_q <= S_DIV;
							end
						end
						OP_POW: begin
							if (y[W-1]) begin
								if (x == W'(1)) tv_q <= W'(1);
								else if (x == '1) tv_q <= y[0] ? '1 : W'(1);
								else tv_q <= '0;
								vcnt_q  <= vcnt_q - 1'b1;
								state_q <= ret_q;
							end else begin
								pr_q    <= W'(1);
								pb_q    <= x;
								pe_q    <= y;
								state_q <= S_POW;
							end
						end
						default: begin
							err_q   <= STAT_MAL;
							state_q <= ret_q;
						end
					endcase
				end
				S_DIV: begin
					// one quotient bit per cycle, restoring
					if (dcnt_q != '0) begin
						if (r2 >= {1'b0, dvs_q}) begin
							rem_q <= W'(r2 - {1'b0, dvs_q});
							quo_q <= {quo_q[W-2:0], 1'b1};
						end else begin
							rem_q <= r2[W-1:0];
							quo_q <= {quo_q[W-2:0], 1'b0};
						end
						dcnt_q <= dcnt_q - 1'b1;
					end else begin
						if (aop_q == OP_DIV) tv_q <= neg_q ? (~quo_q + 1'b1) : quo_q;
						else tv_q <= neg_q ? (~rem_q + 1'b1) : rem_q;
						vcnt_q  <= vcnt_q - 1'b1;
						state_q <= ret_q;
					end
				end
				S_POW: begin
					// square and multiply, one exponent bit per cycle
					if (pe_q == '0) begin
						tv_q    <= pr_q;
						vcnt_q  <= vcnt_q - 1'b1;
						state_q <= ret_q;
					end else begin
						if (pe_q[0]) pr_q <= pmul_r;
						pb_q <= pmul_b;
						pe_q <= pe_q >> 1;
					end
				end
				S_DONE: begin
					if (!ovalid_q) begin
						ovalid_q      <= 1'b1;
						rsp_q.result  <= (err_q == STAT_OK) ? 32'($signed(tv_q)) : '0;
						rsp_q.status  <= err_q;
						err_q         <= STAT_OK;
						vcnt_q        <= '0;
						ocnt_q        <= '0;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp   = rsp_q;
	assign empty = !ovalid_q;

	a_vcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vcnt_q <= CW'(STACK_DEPTH)) else $error("value count beyond depth");
	a_ocnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= CW'(STACK_DEPTH)) else $error("operator count beyond depth");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !ovalid_q) |=>
		(vcnt_q == '0 && ocnt_q == '0 && err_q == STAT_OK && ovalid_q))
		else $error("expression state not cleared after result");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		tok_pop |-> (state_q == S_IDLE)) else $error("token taken while busy");

endmodule
`default_nettype wire

// ----- tb/tb_infix_expression_evaluator.sv -----
`timescale 1ns / 1ps
module tb_infix_expression_evaluator;
	import iee_pkg::*;

	// golden evaluator and store of pending results
	class expr_scoreboard;
		logic [2:0]  ops[32];
		logic [31:0] vals[32];
		int          n_ops;
		int          n_vals;
		logic [1:0]  err;
		rsp_t        pending[$];
		int          n_fail;
		int          n_results;
		int          n_status[4];

		function void clear_stacks();
			n_ops = 0;
			n_vals = 0;
			err = STAT_OK;
		endfunction

		function void flag(logic [1:0] e);
			if (err == STAT_OK)
				err = e;
		endfunction

		function logic [1:0] rank(logic [2:0] op);
			if (op == OP_ADD || op == OP_SUB)
				return 2'd1;
			if (op == OP_MUL || op == OP_DIV || op == OP_MOD)
				return 2'd2;
			if (op == OP_POW)
				return 2'd3;
			return 2'd0;
		endfunction

		function void push_value(logic [31:0] v);
			if (n_vals >= 32)
				flag(STAT_OVF);
			else begin
				vals[n_vals] = v;
				n_vals++;
			end
		endfunction

		function void push_oper(logic [2:0] op);
			if (n_ops >= 32)
				flag(STAT_OVF);
			else begin
				ops[n_ops] = op;
				n_ops++;
			end
		endfunction

		function logic [31:0] int_pow(logic [31:0] x, logic [31:0] y);
			logic [31:0] r;
			logic [31:0] b;
			logic [31:0] e;
			r = 1;
			b = x;
			e = y;
			if (y[31]) begin
				if (x == 32'd1)
					return 32'd1;
				if (x == 32'hFFFF_FFFF)
					return y[0] ? 32'hFFFF_FFFF : 32'd1;
				return 32'd0;
			end
			for (int i = 0; i < 32; i++) begin
				if (e[0])
					r = r * b;
				b = b * b;
				e = e >> 1;
			end
			return r;
		endfunction

		function void apply_op(logic [2:0] op);
			logic [31:0] x;
			logic [31:0] y;
			logic [31:0] z;
			logic [31:0] ux;
			logic [31:0] uy;
			if (err != STAT_OK)
				return;
			if (n_vals < 2) begin
				flag(STAT_MAL);
				return;
			end
			n_vals--;
			y = vals[n_vals];
			n_vals--;
			x = vals[n_vals];
			z = 0;
			case (op)
				OP_ADD: z = x + y;
				OP_SUB: z = x - y;
				OP_MUL: z = x * y;
				OP_DIV, OP_MOD: begin
					if (y == 0) begin
						flag(STAT_DIV0);
						return;
					end
					ux = x[31] ? -x : x;
					uy = y[31] ? -y : y;
					if (op == OP_DIV)
						z = (x[31] != y[31]) ? -(ux / uy) : ux / uy;
					else
						z = x[31] ? -(ux % uy) : ux % uy;
				end
				OP_POW: z = int_pow(x, y);
				default: begin
					flag(STAT_MAL);
					return;
				end
			endcase
			push_value(z);
		endfunction

		function void take_char(logic [7:0] c);
			logic [2:0] op;
			logic [2:0] top;
			if (c >= CH_D0 && c <= CH_D9) begin
				push_value(32'(c - CH_D0));
				return;
			end
			if (c == CH_LPAR) begin
				push_oper(OP_LPAR);
				return;
			end
			if (c == CH_RPAR) begin
				while (n_ops > 0 && ops[n_ops-1] != OP_LPAR && err == STAT_OK) begin
					n_ops--;
					apply_op(ops[n_ops]);
				end
				if (err != STAT_OK)
					return;
				if (n_ops == 0)
					flag(STAT_MAL);
				else
					n_ops--;
				return;
			end
			case (c)
				CH_ADD: op = OP_ADD;
				CH_SUB: op = OP_SUB;
				CH_MUL: op = OP_MUL;
				CH_DIV: op = OP_DIV;
				CH_MOD: op = OP_MOD;
				CH_POW: op = OP_POW;
				default: return;
			endcase
			while (n_ops > 0 && err == STAT_OK) begin
				top = ops[n_ops-1];
				if (top == OP_LPAR || rank(top) < rank(op))
					break;
				n_ops--;
				apply_op(top);
			end
			if (err == STAT_OK)
				push_oper(op);
		endfunction

		// note one accepted input item
		function void note_char(req_t r);
			rsp_t e;
			logic [2:0] top;
			if (err == STAT_OK)
				take_char(r.ch);
			if (!r.last)
				return;
			while (err == STAT_OK && n_ops > 0) begin
				n_ops--;
				top = ops[n_ops];
				if (top == OP_LPAR) begin
					flag(STAT_MAL);
					break;
				end
				apply_op(top);
			end
			if (err == STAT_OK && n_vals != 1)
				flag(STAT_MAL);
			e.status = err;
			e.result = (err == STAT_OK) ? vals[0] : 32'd0;
			pending.push_back(e);
			clear_stacks();
		endfunction

		// compare one popped result with the oldest expectation
		function void check_result(rsp_t a);
			rsp_t e;
			n_results++;
			if (pending.size() == 0) begin
				$error("unexpected result %0d status %0d", a.result, a.status);
				n_fail++;
				return;
			end
			e = pending.pop_front();
			n_status[e.status]++;
			if (a.result !== e.result) begin
				$error("result: expected %0d, got %0d", e.result, a.result);
				n_fail++;
			end
			if (a.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, a.status);
				n_fail++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic pop = 0;
	req_t req = '0;
	logic full;
	logic empty;
	rsp_t rsp;
	int send_idle = 0;
	int recv_stall = 0;
	int n_items = 0;
	expr_scoreboard board = new();

	infix_expression_evaluator uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .rsp(rsp)
	);

	always #5 clk = ~clk;

	// hold the run to a fixed budget
	initial begin
		#60ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// pop results with random stalls
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			board.check_result(rsp);
		pop <= ($urandom_range(99) >= recv_stall);
	end

	// send one character, honoring backpressure; push stays high for the next one
	task automatic send_char(logic [7:0] c, logic l);
		while ($urandom_range(99) < send_idle) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		req <= '{ch: c, last: l};
		@(posedge clk);
		while (full)
			@(posedge clk);
		board.note_char('{ch: c, last: l});
		n_items++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	// drop push and wait for every expected result
	task automatic drain();
		push <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_digit();
		return CH_D0 + 8'($urandom_range(9));
	endfunction

	function automatic logic [7:0] pick_oper();
		case ($urandom_range(5))
			0: return CH_ADD;
			1: return CH_SUB;
			2: return CH_MUL;
			3: return CH_DIV;
			4: return CH_MOD;
			default: return CH_POW;
		endcase
	endfunction

	// build a well-formed expression of random shape
	function automatic string make_expr(int depth);
		string s;
		int n;
		n = $urandom_range(4);
		s = "";
		for (int i = 0; i <= n; i++) begin
			if (i > 0)
				s = {s, string'(pick_oper())};
			if (depth > 0 && $urandom_range(3) == 0)
				s = {s, "(", make_expr(depth - 1), ")"};
			else
				s = {s, string'(pick_digit())};
			if ($urandom_range(15) == 0)
				s = {s, " "};
		end
		return s;
	endfunction

	task automatic random_phase(int count, int idle, int stall);
		string s;
		send_idle = idle;
		recv_stall = stall;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(9))
				0: begin
					// noise, random bytes including all bits
					for (int j = $urandom_range(6); j >= 0; j--)
						send_char(8'($urandom), j == 0);
				end
				1: begin
					// broken: add a trailing operator or a leading '('
					s = make_expr(2);
					if ($urandom_range(1))
						s = {s, string'(pick_oper())};
					else
						s = {"(", s};
					send_text(s);
				end
				default: send_text(make_expr(3));
			endcase
		end
	endtask

	string deep;

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed cases
		send_text("9");
		send_text("1+2*3-4");
		send_text("8/3%2^2");
		send_text("(1-9)/2");
		send_text("(0-7)%3");
		send_text("5/0");
		send_text("4%0+(");
		send_text("2^(0-3)");
		send_text("(0-1)^(0-3)");
		send_text("1^(0-4)");
		send_text("2^9^3");
		send_text("9^9^9");
		send_text("((1-2)*8^9^9-1)/(0-1)");
		send_text("((0-2)^9^9*2)%(0-1)");
		send_text("12");
		send_text(")1");
		send_text("(2");
		send_text("+");
		send_char(8'hFF, 1);
		send_text("7a 0");
		deep = "";
		for (int i = 0; i < 33; i++)
			deep = {deep, "("};
		send_text({deep, "1"});
		deep = "";
		for (int i = 0; i < 33; i++)
			deep = {deep, "1+"};
		send_text({deep, "1"});
		// hold off until every result has come
		drain();

		random_phase(25, 0, 0);
		random_phase(25, 65, 0);
		random_phase(25, 0, 65);
		random_phase(25, 28, 28);
		drain();
		random_phase(20, 0, 0);

		send_idle = 0;
		recv_stall = 0;
		drain();
		repeat (400) @(posedge clk);
		$display("Sent %0d characters, checked %0d results (ok %0d, malformed %0d,",
			n_items, board.n_results, board.n_status[0], board.n_status[1]);
		$display("divide by zero %0d, overflow %0d).", board.n_status[2], board.n_status[3]);
		if (board.n_fail == 0 && board.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/iee_pkg.sv
rtl/iee_front.sv
rtl/iee_back.sv
rtl/infix_expression_evaluator.sv
tb/tb_infix_expression_evaluator.sv
